>>> hw/rtl/opts_pkg.sv
`timescale 1ns / 1ps
// Package: constants, codes and shared types of the timer slot block.
package opts_pkg;

	localparam int SLOTS     = 8;
	localparam int MAX_OUT   = 8;
	localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W     = $clog2(MAX_OUT + 1);
	localparam int READ_WRAP = 1000;
	localparam int READ_MAX  = 999;

	localparam logic [2:0] MODE_TICK    = 3'd0;
	localparam logic [2:0] MODE_START   = 3'd1;
	localparam logic [2:0] MODE_STOP    = 3'd2;
	localparam logic [2:0] MODE_ADD_ONE = 3'd3;
	localparam logic [2:0] MODE_ADD_PER = 3'd4;

	localparam logic [1:0] KIND_FIRED  = 2'd0;
	localparam logic [1:0] KIND_ADD_OK = 2'd1;
	localparam logic [1:0] KIND_FULL   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic accept;
		logic update;
		logic scan;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic tick_go;
		logic scan_end;
	} sts_t;

endpackage

>>> hw/rtl/opts_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences the tick update, the slot scan and the final flush.
module opts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  opts_pkg::sts_t sts,
	output opts_pkg::cmd_t cmd,
	output logic          busy
);
	import opts_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && sts.tick_go) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_update_to_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE |=> state_q == ST_SCAN)
		else $error("update not followed by scan");
	a_flush_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |=> state_q == ST_IDLE)
		else $error("flush not followed by idle");
	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start && sts.tick_go) |=> state_q == ST_UPDATE)
		else $error("running tick did not start an update");
`endif

endmodule

>>> hw/rtl/opts_datapath.sv
`timescale 1ns / 1ps
// Datapath: elapsed count, slot table, scan index and registered result word.
module opts_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  opts_pkg::cmd_t cmd,
	output opts_pkg::sts_t sts,
	input  logic [2:0]     mode,
	input  logic [9:0]     ms_reading,
	input  logic [31:0]    delay_ms,
	input  logic [7:0]     hook_tag,
	output logic           strobe,
	output logic [1:0]     kind,
	output logic [7:0]     tag_out,
	output logic [31:0]    elapsed_out,
	output logic           last
);
	import opts_pkg::*;

	logic [31:0]      elapsed_q;
	logic [9:0]       prev_q;
	logic             running_q;
	logic [9:0]       reading_q;
	logic [SLOTS-1:0] valid_q;
	logic             periodic_q [SLOTS];
	logic [31:0]      time_q     [SLOTS];
	logic [31:0]      lastfire_q [SLOTS];
	logic [7:0]       tag_q      [SLOTS];
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_v_q;
	logic [7:0]       pend_tag_q;
	logic             strobe_q;
	logic [1:0]       kind_q;
	logic [7:0]       tag_out_q;
	logic [31:0]      elapsed_out_q;
	logic             last_q;

	logic [9:0]       rd;
	logic [10:0]      step;
	logic             free_found;
	logic [IDX_W-1:0] free_idx;
	logic             is_add;
	logic             add_ok;
	logic [31:0]      age;
	logic             due;
	logic             fire;
	logic             emit_mid;
	logic             emit_end;

	always_comb begin
		rd = (reading_q > 10'(READ_MAX)) ? 10'(READ_MAX) : reading_q;
		if (rd < prev_q) begin
			step = 11'(READ_WRAP) - {1'b0, prev_q} + {1'b0, rd};
		end else begin
			step = {1'b0, rd} - {1'b0, prev_q};
		end
	end

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign is_add   = cmd.accept && (mode == MODE_ADD_ONE || mode == MODE_ADD_PER);
	assign add_ok   = is_add && free_found;
	assign age      = elapsed_q - lastfire_q[idx_q];
	assign due      = periodic_q[idx_q] ? (age >= time_q[idx_q]) : (elapsed_q >= time_q[idx_q]);
	assign fire     = cmd.scan && valid_q[idx_q] && due && (cnt_q < CNT_W'(MAX_OUT));
	assign emit_mid = fire && pend_v_q;
	assign emit_end = cmd.flush && pend_v_q;

	assign sts.tick_go  = (mode == MODE_TICK) && running_q;
	assign sts.scan_end = (idx_q == IDX_W'(SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			prev_q    <= '0;
			running_q <= 1'b0;
			valid_q   <= '0;
			idx_q     <= '0;
			cnt_q     <= '0;
			pend_v_q  <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= is_add || emit_mid || emit_end;
			if (cmd.accept && mode == MODE_START) begin
				running_q <= 1'b1;
			end
			if (cmd.accept && mode == MODE_STOP) begin
				running_q <= 1'b0;
				prev_q    <= '0;
			end
			if (add_ok) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (cmd.update) begin
				elapsed_q <= elapsed_q + 32'(step);
				prev_q    <= rd;
				idx_q     <= '0;
				cnt_q     <= '0;
				pend_v_q  <= 1'b0;
			end
			if (cmd.scan) begin
				idx_q <= idx_q + 1'b1;
			end
			if (fire) begin
				cnt_q    <= cnt_q + 1'b1;
				pend_v_q <= 1'b1;
				if (!periodic_q[idx_q]) begin
					valid_q[idx_q] <= 1'b0;
				end
			end
			if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			reading_q <= ms_reading;
		end
		if (add_ok) begin
			periodic_q[free_idx] <= (mode == MODE_ADD_PER);
			time_q[free_idx]     <= (mode == MODE_ADD_PER) ? delay_ms : elapsed_q + delay_ms;
			lastfire_q[free_idx] <= elapsed_q;
			tag_q[free_idx]      <= hook_tag;
		end
		if (fire) begin
			pend_tag_q <= tag_q[idx_q];
			if (periodic_q[idx_q]) begin
				lastfire_q[idx_q] <= elapsed_q;
			end
		end
		if (is_add) begin
			kind_q        <= free_found ? KIND_ADD_OK : KIND_FULL;
			tag_out_q     <= hook_tag;
			elapsed_out_q <= elapsed_q;
			last_q        <= 1'b1;
		end else if (emit_mid || emit_end) begin
			kind_q        <= KIND_FIRED;
			tag_out_q     <= pend_tag_q;
			elapsed_out_q <= elapsed_q;
			last_q        <= emit_end;
		end
	end

	assign strobe      = strobe_q;
	assign kind        = kind_q;
	assign tag_out     = tag_out_q;
	assign elapsed_out = elapsed_out_q;
	assign last        = last_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_OUT))
		else $error("fire count past limit");
	a_mid_word: assert property (@(posedge clk) disable iff (!arst_n)
		emit_mid |=> strobe_q && !last_q && kind_q == KIND_FIRED)
		else $error("held fire word not sent");
	a_end_word: assert property (@(posedge clk) disable iff (!arst_n)
		emit_end |=> strobe_q && last_q && kind_q == KIND_FIRED)
		else $error("final fire word not sent");
`endif

endmodule

>>> hw/rtl/oneshot_periodic_timer_slots.sv
`timescale 1ns / 1ps
// Top level: millisecond timer with a table of one-shot and periodic slots.
// A command word is taken when start is high and busy is low. Start, stop,
// add and a tick while stopped leave busy low, so the next word can follow
// at once; an add result appears on the cycle after acceptance. A tick while
// running keeps busy high after acceptance through an update state, a scan
// state that steps through the slots with a single slot compare, and a
// flush state. Each result word is valid for exactly one cycle while
// strobe is high and cannot be held off; last marks the final word of a
// command. A fired word is held until the next due slot is found or the flush
// state is reached, and goes out on the cycle after that, so the final one
// follows the flush cycle.
module oneshot_periodic_timer_slots (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [9:0]  ms_reading,
	input  logic [31:0] delay_ms,
	input  logic [7:0]  hook_tag,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [7:0]  tag_out,
	output logic [31:0] elapsed_out,
	output logic        last
);
	import opts_pkg::*;

	cmd_t cmd;
	sts_t sts;

	opts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	opts_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.ms_reading  (ms_reading),
		.delay_ms    (delay_ms),
		.hook_tag    (hook_tag),
		.strobe      (strobe),
		.kind        (kind),
		.tag_out     (tag_out),
		.elapsed_out (elapsed_out),
		.last        (last)
	);

endmodule

>>> tb/sv/oneshot_periodic_timer_slots_tb.sv
`timescale 1ns / 1ps
// Testbench: timer slot block driven with directed and random command words, checked against a local predictor.
module oneshot_periodic_timer_slots_tb;
	import opts_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_WORDS = 410;

	typedef struct packed {
		logic [2:0]  mode;
		logic [9:0]  reading;
		logic [31:0] delay;
		logic [7:0]  tag;
		logic        hold;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tag;
		logic [31:0] elapsed;
		logic        last;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  mode = MODE_START;
	logic [9:0]  ms_reading = '0;
	logic [31:0] delay_ms = '0;
	logic [7:0]  hook_tag = '0;
	logic        strobe;
	logic [1:0]  kind;
	logic [7:0]  tag_out;
	logic [31:0] elapsed_out;
	logic        last;

	cmd_word_t cmd_backlog[$];
	result_t   timer_events[$];
	cmd_word_t cur_word;
	int        n_accepted = 0;
	int        n_errors = 0;
	int        n_cycles = 0;

	// predicted timer state
	logic [31:0] tm_elapsed = '0;
	logic [9:0]  tm_prev = '0;
	logic        tm_running = 1'b0;
	logic        sl_used[SLOTS];
	logic        sl_periodic[SLOTS];
	logic [31:0] sl_when[SLOTS];
	logic [31:0] sl_last[SLOTS];
	logic [7:0]  sl_tag[SLOTS];

	oneshot_periodic_timer_slots dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.ms_reading(ms_reading),
		.delay_ms(delay_ms),
		.hook_tag(hook_tag),
		.strobe(strobe),
		.kind(kind),
		.tag_out(tag_out),
		.elapsed_out(elapsed_out),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic advance_timer(input cmd_word_t w);
		logic [9:0] rd;
		logic       due;
		logic       have;
		int         n;
		int         free_idx;
		result_t    r;
		have = 1'b0;
		n = 0;
		free_idx = -1;
		case (w.mode)
			MODE_TICK: begin
				if (tm_running) begin
					rd = (w.reading > READ_MAX) ? 10'(READ_MAX) : w.reading;
					if (rd < tm_prev)
						tm_elapsed += READ_WRAP - int'(tm_prev) + int'(rd);
					else
						tm_elapsed += int'(rd) - int'(tm_prev);
					tm_prev = rd;
					for (int i = 0; i < SLOTS; i++) begin
						if (sl_used[i] && n < MAX_OUT) begin
							if (sl_periodic[i])
								due = (tm_elapsed - sl_last[i]) >= sl_when[i];
							else
								due = tm_elapsed >= sl_when[i];
							if (due) begin
								if (have)
									timer_events.push_back(r);
								r = '{KIND_FIRED, sl_tag[i], tm_elapsed, 1'b0};
								have = 1'b1;
								n++;
								if (sl_periodic[i])
									sl_last[i] = tm_elapsed;
								else
									sl_used[i] = 1'b0;
							end
						end
					end
					if (have) begin
						r.last = 1'b1;
						timer_events.push_back(r);
					end
				end
			end
			MODE_START: tm_running = 1'b1;
			MODE_STOP: begin
				tm_prev = '0;
				tm_running = 1'b0;
			end
			MODE_ADD_ONE, MODE_ADD_PER: begin
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!sl_used[i])
						free_idx = i;
				if (free_idx < 0) begin
					timer_events.push_back('{KIND_FULL, w.tag, tm_elapsed, 1'b1});
				end else begin
					sl_used[free_idx] = 1'b1;
					sl_periodic[free_idx] = (w.mode == MODE_ADD_PER);
					sl_when[free_idx] = (w.mode == MODE_ADD_PER) ? w.delay : tm_elapsed + w.delay;
					sl_last[free_idx] = tm_elapsed;
					sl_tag[free_idx] = w.tag;
					timer_events.push_back('{KIND_ADD_OK, w.tag, tm_elapsed, 1'b1});
				end
			end
			default: ;
		endcase
	endtask

	task automatic flag_word(input string what, input result_t want, input result_t got);
		n_errors++;
		if (n_errors <= 10)
			$display("%s: expected kind=%0d tag=%0d elapsed=%0d last=%0d, got kind=%0d tag=%0d elapsed=%0d last=%0d",
				what, want.kind, want.tag, want.elapsed, want.last,
				got.kind, got.tag, got.elapsed, got.last);
	endtask

	function automatic void queue_cmd(input logic [2:0] m, input int rd, input logic [31:0] d,
		input int tg, input logic hold = 1'b0);
		cmd_backlog.push_back('{m, 10'(rd), d, 8'(tg), hold});
	endfunction

	// driver: one word in flight on the ports, replaced once accepted
	always @(posedge clk) begin
		cmd_word_t nxt;
		int        idle_pct;
		if (arst_n && !(start && busy)) begin
			if (start) begin
				advance_timer(cur_word);
				n_accepted++;
			end
			idle_pct = (n_accepted < 120) ? 0 : (n_accepted < 240) ? 58 :
				(n_accepted < 330) ? 0 : 27;
			if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
				!(cmd_backlog[0].hold && (timer_events.size() != 0 || busy))) begin
				nxt = cmd_backlog.pop_front();
				cur_word = nxt;
				start <= 1'b1;
				mode <= nxt.mode;
				ms_reading <= nxt.reading;
				delay_ms <= nxt.delay;
				hook_tag <= nxt.tag;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && strobe) begin
			got = '{kind, tag_out, elapsed_out, last};
			if (timer_events.size() == 0) begin
				flag_word("unexpected word", '0, got);
			end else begin
				want = timer_events.pop_front();
				if (got != want)
					flag_word("mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int r;
		int per_left;
		int rd;
		per_left = 3;
		for (int i = 0; i < SLOTS; i++)
			sl_used[i] = 1'b0;

		// directed
		queue_cmd(MODE_TICK, 500, 32'h0, 8'h11);
		queue_cmd(3'd5, 1023, 32'hFFFF_FFFF, 8'hFF);
		queue_cmd(3'd6, 0, 32'h0, 8'h00);
		queue_cmd(3'd7, 341, 32'h5555_5555, 8'hAA);
		queue_cmd(MODE_ADD_ONE, 0, 32'h0, 8'h00);
		queue_cmd(MODE_START, 0, 32'h0, 8'h0);
		queue_cmd(MODE_START, 0, 32'h0, 8'h0);
		queue_cmd(MODE_TICK, 0, 32'h0, 8'h0);
		queue_cmd(MODE_ADD_PER, 0, 32'h0, 8'hFF);
		queue_cmd(MODE_TICK, 1023, 32'h0, 8'h0);
		queue_cmd(MODE_TICK, 5, 32'h0, 8'h0);
		queue_cmd(MODE_ADD_ONE, 0, 32'hFFFF_FFFF, 8'h5A);
		for (int k = 1; k <= 6; k++)
			queue_cmd(MODE_ADD_ONE, 0, 32'(1000 * k + 500), 8'h10 + k);
		queue_cmd(MODE_ADD_ONE, 0, 32'd7, 8'hC3);
		queue_cmd(MODE_ADD_PER, 0, 32'd9, 8'h3C);
		queue_cmd(MODE_TICK, 5, 32'h0, 8'h0);
		queue_cmd(MODE_STOP, 0, 32'h0, 8'h0, 1'b1);
		queue_cmd(MODE_STOP, 0, 32'h0, 8'h0);
		queue_cmd(MODE_TICK, 700, 32'h0, 8'h0);
		queue_cmd(MODE_START, 0, 32'h0, 8'h0);
		queue_cmd(MODE_TICK, 999, 32'h0, 8'h0);

		// random: mostly ticks and adds with short delays while running
		for (int k = 0; k < RANDOM_WORDS; k++) begin
			r = $urandom_range(0, 99);
			rd = $urandom_range(0, 1023);
			if (r < 55) begin
				queue_cmd(MODE_TICK, rd, $urandom, $urandom_range(0, 255), (k % 60) == 59);
			end else if (r < 75) begin
				if (r >= 72 && per_left > 0) begin
					per_left--;
					queue_cmd(MODE_ADD_PER, rd, $urandom_range(0, 3000), $urandom_range(0, 255));
				end else if ($urandom_range(0, 99) < 15) begin
					queue_cmd(MODE_ADD_ONE, rd, 32'hFFFF_FFFF - $urandom_range(0, 1000),
						$urandom_range(0, 255));
				end else begin
					queue_cmd(MODE_ADD_ONE, rd, $urandom_range(0, 3000), $urandom_range(0, 255));
				end
			end else if (r < 82) begin
				queue_cmd(MODE_START, rd, $urandom, $urandom_range(0, 255));
			end else if (r < 85) begin
				queue_cmd(MODE_STOP, rd, $urandom, $urandom_range(0, 255));
			end else if (r < 89) begin
				queue_cmd(3'($urandom_range(5, 7)), rd, $urandom, $urandom_range(0, 255));
			end else begin
				queue_cmd(MODE_TICK, $urandom_range(990, 1023), $urandom, $urandom_range(0, 255));
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || start)
			@(posedge clk);
		while (timer_events.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 12) @(posedge clk);
		n_errors += timer_events.size();
		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
